FILE: hw/rtl/bhpq_pkg.sv
// shared types and constants for the binary heap priority queue
// no dependencies; imported by bhpq_rank and binary_heap_priority_queue
package bhpq_pkg;

	localparam int CAPACITY = 1024;
	localparam int KEY_W    = 32;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	// child index width: holds 2*pos+2 and any count
	localparam int EXT_W    = IDX_W + 2;

	typedef logic [KEY_W-1:0] key_t;
	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [EXT_W-1:0] ext_t;

	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_REMOVE = 1'b1;

	localparam logic CFG_MIN_FIRST   = 1'b0;
	localparam logic CFG_SIGNED_KEYS = 1'b1;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_UP_CHK,
		S_UP_CMP,
		S_DN_KEY,
		S_DN_CHK,
		S_DN_L,
		S_DN_R,
		S_DN_CMP
	} state_t;

	// ordering mode, shared with the compare unit
	typedef struct packed {
		logic min_first;
		logic signed_keys;
	} order_t;

endpackage

FILE: hw/rtl/bhpq_rank.sv
// key compare unit: tells whether key b strictly outranks key a
// depends on bhpq_pkg for the key and order types
module bhpq_rank (
	input  bhpq_pkg::key_t   a,
	input  bhpq_pkg::key_t   b,
	input  bhpq_pkg::order_t order,
	output logic             outranks
);
	import bhpq_pkg::*;

	key_t a_u;
	key_t b_u;

	// flipping the sign bit turns a two's complement compare into an unsigned one
	always_comb begin
		a_u = a;
		b_u = b;
		if (order.signed_keys) begin
			a_u[KEY_W-1] = ~a[KEY_W-1];
			b_u[KEY_W-1] = ~b[KEY_W-1];
		end
		outranks = order.min_first ? (b_u < a_u) : (a_u < b_u);
	end

endmodule

FILE: hw/rtl/binary_heap_priority_queue.sv
// binary heap priority queue: sequencer, key store and one shared compare unit
// depends on bhpq_pkg and bhpq_rank
//
// channel   signals                                         handshake
// request   req_type, key_value                             start & !busy
// result    status, removed_value, top_value, top_valid,    done (one cycle, no stall)
//           entry_count
// config    cfg_index, cfg_data                             cfg_we
//
// insert: accept, a parent read and a compare per level climbed, then a final write
// remove: fetch the last entry, then per level descended (left read, right read and
// child compare if a right child exists, key compare), all on the single read port
// of the key store and the one compare unit; full, empty and single-key cases
// finish from idle; busy stays high until the result strobe; reset empties the store
module binary_heap_priority_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic                   req_type,
	input  logic [31:0]            key_value,
	input  logic                   cfg_we,
	input  logic                   cfg_index,
	input  logic                   cfg_data,
	output logic                   done,
	output logic [1:0]             status,
	output logic [31:0]            removed_value,
	output logic [31:0]            top_value,
	output logic                   top_valid,
	output logic [10:0]            entry_count
);
	import bhpq_pkg::*;

	state_t  state_q, state_d;
	cnt_t    cnt_q;
	logic    done_q;
	status_t status_q;
	key_t    removed_q;
	key_t    top_q;
	key_t    key_q;
	key_t    lkey_q;
	key_t    best_val_q;
	idx_t    best_idx_q;
	idx_t    pos_q;
	order_t  order_q;

	key_t    mem [CAPACITY];
	key_t    rd_data_q;
	logic    rd_en;
	idx_t    rd_addr;
	logic    wr_en;
	idx_t    wr_addr;
	key_t    wr_data;

	key_t    cmp_a;
	key_t    cmp_b;
	logic    outr;

	logic    finish;
	status_t fin_status;
	logic    accept;
	idx_t    parent;
	ext_t    left;
	ext_t    right;
	ext_t    size_ext;
	logic    has_left;
	logic    has_right;

	bhpq_rank u_rank (
		.a        (cmp_a),
		.b        (cmp_b),
		.order    (order_q),
		.outranks (outr)
	);

	assign accept    = start && (state_q == S_IDLE);
	assign parent    = idx_t'(pos_q - idx_t'(1)) >> 1;
	assign left      = {1'b0, pos_q, 1'b1};
	assign right     = left + ext_t'(1);
	assign size_ext  = ext_t'(cnt_q);
	assign has_left  = left < size_ext;
	assign has_right = right < size_ext;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					if (req_type == REQ_INSERT) begin
						if (cnt_q != cnt_t'(CAPACITY)) state_d = S_UP_CHK;
					end else if (cnt_q > cnt_t'(1)) begin
						state_d = S_DN_KEY;
					end
				end
			end
			S_UP_CHK: state_d = (pos_q == '0) ? S_IDLE : S_UP_CMP;
			S_UP_CMP: state_d = outr ? S_UP_CHK : S_IDLE;
			S_DN_KEY: state_d = S_DN_CHK;
			S_DN_CHK: state_d = has_left ? S_DN_L : S_IDLE;
			S_DN_L:   state_d = has_right ? S_DN_R : S_DN_CMP;
			S_DN_R:   state_d = S_DN_CMP;
			S_DN_CMP: state_d = outr ? S_DN_CHK : S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// datapath controls
	always_comb begin
		rd_en      = 1'b0;
		rd_addr    = '0;
		wr_en      = 1'b0;
		wr_addr    = pos_q;
		wr_data    = key_q;
		cmp_a      = key_q;
		cmp_b      = rd_data_q;
		finish     = 1'b0;
		fin_status = ST_DONE;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					if (req_type == REQ_INSERT) begin
						if (cnt_q == cnt_t'(CAPACITY)) begin
							finish     = 1'b1;
							fin_status = ST_FULL;
						end
					end else if (cnt_q == '0) begin
						finish     = 1'b1;
						fin_status = ST_EMPTY;
					end else if (cnt_q == cnt_t'(1)) begin
						finish = 1'b1;
					end else begin
						// fetch the last entry, it becomes the new root
						rd_en   = 1'b1;
						rd_addr = idx_t'(cnt_q - cnt_t'(1));
					end
				end
			end
			S_UP_CHK: begin
				if (pos_q == '0) begin
					wr_en  = 1'b1;
					finish = 1'b1;
				end else begin
					rd_en   = 1'b1;
					rd_addr = parent;
				end
			end
			S_UP_CMP: begin
				cmp_a = rd_data_q;
				cmp_b = key_q;
				wr_en = 1'b1;
				if (outr) begin
					// parent moves down into the hole
					wr_data = rd_data_q;
				end else begin
					finish = 1'b1;
				end
			end
			S_DN_CHK: begin
				if (has_left) begin
					rd_en   = 1'b1;
					rd_addr = left[IDX_W-1:0];
				end else begin
					wr_en  = 1'b1;
					finish = 1'b1;
				end
			end
			S_DN_L: begin
				if (has_right) begin
					rd_en   = 1'b1;
					rd_addr = right[IDX_W-1:0];
				end
			end
			S_DN_R: begin
				// right child wins ties
				cmp_a = rd_data_q;
				cmp_b = lkey_q;
			end
			S_DN_CMP: begin
				cmp_a = key_q;
				cmp_b = best_val_q;
				wr_en = 1'b1;
				if (outr) begin
					wr_data = best_val_q;
				end else begin
					finish = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
			order_q <= '0;
		end else begin
			state_q <= state_d;
			done_q  <= finish;
			if (accept) begin
				if (req_type == REQ_INSERT) begin
					if (cnt_q != cnt_t'(CAPACITY)) cnt_q <= cnt_q + cnt_t'(1);
				end else if (cnt_q != '0) begin
					cnt_q <= cnt_q - cnt_t'(1);
				end
			end
			if (cfg_we) begin
				if (cfg_index == CFG_MIN_FIRST) begin
					order_q.min_first <= cfg_data;
				end else begin
					order_q.signed_keys <= cfg_data;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (finish) status_q <= fin_status;
		if (accept) begin
			key_q <= key_value;
			pos_q <= cnt_q[IDX_W-1:0];
			removed_q <= (req_type == REQ_REMOVE && cnt_q != '0) ? top_q : '0;
		end
		if (wr_en && wr_addr == '0) top_q <= wr_data;
		case (state_q)
			S_UP_CMP: begin
				if (outr) pos_q <= parent;
			end
			S_DN_KEY: begin
				key_q <= rd_data_q;
				pos_q <= '0;
			end
			S_DN_L: begin
				lkey_q     <= rd_data_q;
				best_val_q <= rd_data_q;
				best_idx_q <= left[IDX_W-1:0];
			end
			S_DN_R: begin
				if (!outr) begin
					best_val_q <= rd_data_q;
					best_idx_q <= right[IDX_W-1:0];
				end
			end
			S_DN_CMP: begin
				if (outr) pos_q <= best_idx_q;
			end
			default: begin
			end
		endcase
	end

	// key store: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (rd_en) rd_data_q <= mem[rd_addr];
	end

	assign busy          = (state_q != S_IDLE);
	assign done          = done_q;
	assign status        = status_q;
	assign removed_value = removed_q;
	assign top_valid     = (cnt_q != '0);
	assign top_value     = top_valid ? top_q : '0;
	assign entry_count   = cnt_q;

	a_full_only_at_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && status_q == ST_FULL |-> cnt_q == cnt_t'(CAPACITY))
		else $error("full status with free entries");

	a_empty_reports_nothing: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && status_q == ST_EMPTY |-> cnt_q == '0 && removed_q == '0)
		else $error("empty status with keys held or a removed key");

	a_no_write_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> state_q != S_IDLE)
		else $error("store written outside a sift");

	a_no_port_clash: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en && wr_en |-> rd_addr != wr_addr)
		else $error("read and write hit the same entry");

	a_result_ends_work: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> state_q == S_IDLE || $past(accept))
		else $error("result strobe while a sift is still running");

endmodule
